// ----- rtl/i2cm_pkg.sv -----
// Shared types, constants and delay helper for the I2C master bit sequencer.
package i2cm_pkg;

    localparam int DELAY_COUNT_BITS = 12;
    localparam int TPU_W            = 10;
    localparam int LIMIT_W          = 8;
    localparam int CMP_W = (DELAY_COUNT_BITS > TPU_W + 3) ? DELAY_COUNT_BITS : TPU_W + 3;

    localparam logic [CMP_W-1:0] DLY_MAX = CMP_W'((64'd1 << DELAY_COUNT_BITS) - 64'd1);

    // request codes
    localparam logic [2:0] REQ_NONE     = 3'd0;
    localparam logic [2:0] REQ_START    = 3'd1;
    localparam logic [2:0] REQ_STOP     = 3'd2;
    localparam logic [2:0] REQ_WRITE    = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;
    localparam logic [2:0] REQ_WAIT_ACK = 3'd5;

    // register indexes
    localparam logic REG_TPU   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [TPU_W-1:0]   TPU_RST   = TPU_W'(50);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(250);

    // delay lengths as left shifts of one unit
    localparam logic [1:0] UNITS_1 = 2'd0;
    localparam logic [1:0] UNITS_2 = 2'd1;
    localparam logic [1:0] UNITS_4 = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_out_item;

    typedef struct packed {
        logic [TPU_W-1:0]   ticks_per_unit;
        logic [LIMIT_W-1:0] ack_poll_limit;
    } t_cfg;

    // units * ticks, saturated to the counter range, at least one tick
    function automatic logic [DELAY_COUNT_BITS-1:0] dly_load(
        input logic [1:0]       shamt,
        input logic [TPU_W-1:0] tpu
    );
        logic [CMP_W-1:0] prod;
        prod = CMP_W'(tpu) << shamt;
        if (prod > DLY_MAX) begin
            prod = DLY_MAX;
        end
        if (prod == '0) begin
            prod = CMP_W'(1);
        end
        return prod[DELAY_COUNT_BITS-1:0];
    endfunction

endpackage

// ----- rtl/i2cm_regs.sv -----
// APB-style configuration registers: tick count per unit and ACK poll limit.
module i2cm_regs
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic               r_wr_unused;
    logic [TPU_W-1:0]   r_tpu;
    logic [LIMIT_W-1:0] r_limit;
    logic               wr_en;
    logic               idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu       <= TPU_RST;
            r_limit     <= LIMIT_RST;
            r_wr_unused <= 1'b0;
        end else if (wr_en) begin
            r_wr_unused <= 1'b0;
            case (idx)
                REG_TPU:   r_tpu   <= pwdata[TPU_W-1:0];
                REG_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                default:   r_wr_unused <= 1'b1;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TPU:   prdata = 32'(r_tpu);
            REG_LIMIT: prdata = 32'(r_limit);
            default:   prdata = 32'(r_wr_unused);
        endcase
    end

    assign o_cfg.ticks_per_unit = r_tpu;
    assign o_cfg.ack_poll_limit = r_limit;

endmodule

// ----- rtl/i2cm_seq.sv -----
// Bus sequencer: phase state, delay counter, shifter and line levels, one tick per step.
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_item
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WA_A, PH_WA_B, PH_WA_POLL,
        PH_WR_LOW, PH_WR_HIGH, PH_WR_TAIL, PH_RD_LOW, PH_RD_HIGH, PH_AK_LOW, PH_AK_HIGH
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [3:0]                  r_bit, n_bit;
    logic [DELAY_COUNT_BITS-1:0] r_dly, n_dly;
    logic [7:0]                  r_shift, n_shift;
    logic [7:0]                  r_poll, n_poll;
    logic                        r_ack_choice, n_ack_choice;
    logic                        r_scl, n_scl;
    logic                        r_sda, n_sda;
    logic                        r_drive, n_drive;
    logic                        r_err, n_err;
    logic [7:0]                  r_rx, n_rx;

    logic                        done;
    logic                        do_poll;
    logic [3:0]                  bit_inc;
    logic [DELAY_COUNT_BITS-1:0] d_dec;
    logic [DELAY_COUNT_BITS-1:0] dly1, dly2, dly4;

    assign dly1    = dly_load(UNITS_1, i_cfg.ticks_per_unit);
    assign dly2    = dly_load(UNITS_2, i_cfg.ticks_per_unit);
    assign dly4    = dly_load(UNITS_4, i_cfg.ticks_per_unit);
    assign bit_inc = r_bit + 4'd1;
    assign d_dec   = (r_dly != '0) ? r_dly - DELAY_COUNT_BITS'(1) : r_dly;

    always_comb begin
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_dly        = r_dly;
        n_shift      = r_shift;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drive      = r_drive;
        n_err        = r_err;
        n_rx         = r_rx;
        done         = 1'b0;
        do_poll      = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.req_type >= REQ_START && i_item.req_type <= REQ_WAIT_ACK) begin
                    n_bit  = '0;
                    n_poll = '0;
                end
                case (i_item.req_type)
                    REQ_START: begin
                        n_drive = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_dly = dly4; n_phase = PH_ST_A;
                    end
                    REQ_STOP: begin
                        n_drive = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_dly = dly4; n_phase = PH_SP_A;
                    end
                    REQ_WRITE: begin
                        n_drive = 1'b1; n_scl = 1'b0;
                        n_sda   = i_item.tx_byte[7];
                        n_shift = {i_item.tx_byte[6:0], 1'b0};
                        n_dly = dly2; n_phase = PH_WR_LOW;
                    end
                    REQ_READ: begin
                        n_drive = 1'b0; n_ack_choice = i_item.send_ack;
                        n_shift = '0; n_scl = 1'b0;
                        n_dly = dly2; n_phase = PH_RD_LOW;
                    end
                    REQ_WAIT_ACK: begin
                        n_drive = 1'b0; n_sda = 1'b1;
                        n_dly = dly1; n_phase = PH_WA_A;
                    end
                    default: ;
                endcase
            end
            PH_WA_POLL: do_poll = 1'b1;
            default: begin
                n_dly = d_dec;
                if (d_dec == '0) begin
                    case (r_phase)
                        PH_ST_A: begin
                            n_sda = 1'b0; n_dly = dly4; n_phase = PH_ST_B;
                        end
                        PH_ST_B: begin
                            n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                        end
                        PH_SP_A: begin
                            n_scl = 1'b1; n_sda = 1'b1; n_dly = dly4; n_phase = PH_SP_B;
                        end
                        PH_SP_B: begin
                            n_phase = PH_IDLE; done = 1'b1;
                        end
                        PH_WA_A: begin
                            n_scl = 1'b1; n_dly = dly1; n_phase = PH_WA_B;
                        end
                        PH_WA_B: do_poll = 1'b1;
                        PH_WR_LOW: begin
                            n_scl = 1'b1; n_dly = dly2; n_phase = PH_WR_HIGH;
                        end
                        PH_WR_HIGH: begin
                            n_scl = 1'b0; n_dly = dly2; n_phase = PH_WR_TAIL;
                        end
                        PH_WR_TAIL: begin
                            n_bit = bit_inc;
                            if (bit_inc >= 4'd8) begin
                                n_phase = PH_IDLE; done = 1'b1;
                            end else begin
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                                n_dly = dly2; n_phase = PH_WR_LOW;
                            end
                        end
                        PH_RD_LOW: begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_dly = dly1; n_phase = PH_RD_HIGH;
                        end
                        PH_RD_HIGH: begin
                            n_bit = bit_inc;
                            n_scl = 1'b0;
                            n_dly = dly2;
                            if (bit_inc >= 4'd8) begin
                                n_rx    = r_shift;
                                n_drive = 1'b1;
                                n_sda   = !r_ack_choice;
                                n_phase = PH_AK_LOW;
                            end else begin
                                n_phase = PH_RD_LOW;
                            end
                        end
                        PH_AK_LOW: begin
                            n_scl = 1'b1; n_dly = dly2; n_phase = PH_AK_HIGH;
                        end
                        PH_AK_HIGH: begin
                            n_scl = 1'b0; n_phase = PH_IDLE; done = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE; done = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        // one SDA poll of the acknowledge wait
        if (do_poll) begin
            n_phase = PH_WA_POLL;
            if (!i_item.sda_in) begin
                n_scl = 1'b0; n_err = 1'b0; n_phase = PH_IDLE; done = 1'b1;
            end else if (r_poll >= i_cfg.ack_poll_limit) begin
                n_err = 1'b1;
                n_drive = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                n_dly = dly4; n_phase = PH_SP_A;
            end else begin
                n_poll = r_poll + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit        <= '0;
            r_dly        <= '0;
            r_shift      <= '0;
            r_poll       <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drive      <= 1'b0;
            r_err        <= 1'b0;
            r_rx         <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit        <= n_bit;
            r_dly        <= n_dly;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drive      <= n_drive;
            r_err        <= n_err;
            r_rx         <= n_rx;
        end
    end

    assign o_item.scl_out   = n_scl;
    assign o_item.sda_out   = n_sda;
    assign o_item.sda_drive = n_drive;
    assign o_item.busy_res  = (n_phase != PH_IDLE);
    assign o_item.done_res  = done;
    assign o_item.rx_byte   = n_rx;
    assign o_item.ack_error = n_err;

    // a finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && done) |-> !o_item.busy_res)
        else $error("done with busy still set");

    // SDA stays released while the read bits are clocked in
    a_read_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RD_LOW || r_phase == PH_RD_HIGH) |-> !r_drive)
        else $error("SDA driven during read");

    // every timed phase holds a live delay
    a_delay_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && r_phase != PH_WA_POLL) |-> (r_dly != '0))
        else $error("timed phase with empty delay");

    // bit count never passes one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_bit <= 4'd8))
        else $error("bit counter past eight");

endmodule

// ----- rtl/i2c_master_bit_sequencer.sv -----
// I2C master bit sequencer top level: tick input register, sequencer, result register, config port.
// An accepted tick beat reaches the output through the input register and then the result register.
// Throughput: one tick beat per cycle while the output is not stalled; the sequencer state updates once per tick beat.
// Bus timing is counted in tick beats, not clock cycles; a stalled output holds the tick.
// Reset (i_rst_n low, synchronous): idle, SCL and SDA high, SDA released, no beats held,
// ticks_per_unit 50, ack_poll_limit 250.
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick beats in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // result beats out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      cfg;
    t_out_item seq_item;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      out_free;
    logic      step;
    logic      in_take;

    // Result register frees when empty or being taken this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    // The held tick is processed exactly when its result has somewhere to go.
    assign step       = r_in_valid && out_free;
    // Input register takes a new beat whenever it empties (or already is empty).
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (step) begin
            r_out_data <= seq_item;
        end
    end

    i2cm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // All per-tick work: one pass of phase logic from held tick to result.
    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_item  (seq_item)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
